// File: sv/ppc_pkg.sv
// Shared widths, register indexes and controller/datapath interface types.
package ppc_pkg;

  localparam int CountBits = 32;
  localparam int CfgAddrBits = 4;
  localparam int InBits = 168;
  localparam int OutBits = 40;

  // Both the root and the quotient are produced one bit per step.
  localparam int StepBits = 5;
  localparam logic [StepBits-1:0] LastStep = StepBits'(30);

  localparam logic [CfgAddrBits-1:0] RegHalfSize = CfgAddrBits'(0);
  localparam logic [CfgAddrBits-1:0] RegPlane = CfgAddrBits'(1);

  localparam logic [30:0] HalfSizeReset = 31'd327680;
  localparam logic signed [31:0] PlaneReset = 32'sd6553600;
  localparam logic [63:0] OneQ60 = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic load;
    logic sq_u;
    logic sq_v;
    logic sum;
    logic root_load;
    logic root_step;
    logic div_load;
    logic div_step;
    logic mul_x;
    logic mul_y;
    logic chk_y;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic w_zero;
    logic div_ovf;
  } sts_t;

endpackage

// File: sv/ppc_ctrl.sv
// Sequencing state machine for one particle and the output valid flag.
module ppc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  ppc_pkg::sts_t sts,
  output ppc_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    IDLE      = 13'b0_0000_0000_0001,
    SQ_U      = 13'b0_0000_0000_0010,
    SQ_V      = 13'b0_0000_0000_0100,
    SUM       = 13'b0_0000_0000_1000,
    ROOT_LOAD = 13'b0_0000_0001_0000,
    ROOT      = 13'b0_0000_0010_0000,
    DIV_LOAD  = 13'b0_0000_0100_0000,
    BRANCH    = 13'b0_0000_1000_0000,
    DIV       = 13'b0_0001_0000_0000,
    MUL_X     = 13'b0_0010_0000_0000,
    MUL_Y     = 13'b0_0100_0000_0000,
    CHK_Y     = 13'b0_1000_0000_0000,
    DONE      = 13'b1_0000_0000_0000
  } state_t;

  state_t state, state_next;
  logic [ppc_pkg::StepBits-1:0] step, step_next;
  logic m_tvalid_next;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE);

  always_comb begin
    state_next = state;
    step_next = step;
    cmd = '0;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = SQ_U;
        end
      end
      SQ_U: begin
        cmd.sq_u = 1'b1;
        state_next = SQ_V;
      end
      SQ_V: begin
        cmd.sq_v = 1'b1;
        state_next = SUM;
      end
      SUM: begin
        cmd.sum = 1'b1;
        state_next = ROOT_LOAD;
      end
      ROOT_LOAD: begin
        cmd.root_load = 1'b1;
        step_next = '0;
        state_next = ROOT;
      end
      ROOT: begin
        cmd.root_step = 1'b1;
        step_next = step + 1'b1;
        if (step == ppc_pkg::LastStep) begin
          state_next = DIV_LOAD;
        end
      end
      DIV_LOAD: begin
        cmd.div_load = 1'b1;
        step_next = '0;
        state_next = BRANCH;
      end
      BRANCH: begin
        // A zero w or an oversized quotient skips straight to the result.
        if (sts.w_zero || sts.div_ovf) begin
          state_next = DONE;
        end else begin
          state_next = DIV;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        step_next = step + 1'b1;
        if (step == ppc_pkg::LastStep) begin
          state_next = MUL_X;
        end
      end
      MUL_X: begin
        cmd.mul_x = 1'b1;
        state_next = MUL_Y;
      end
      MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_next = CHK_Y;
      end
      CHK_Y: begin
        cmd.chk_y = 1'b1;
        state_next = DONE;
      end
      DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// File: sv/ppc_dp.sv
// Datapath: config registers, squares, bit-serial root, restoring divide, projection, counter.
module ppc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ppc_pkg::cmd_t                     cmd,
  output ppc_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [ppc_pkg::CfgAddrBits-1:0]   cfg_addr,
  input  logic [31:0]                       cfg_data,
  input  logic signed [7:0]                 type_byte,
  input  logic signed [31:0]                pos_x,
  input  logic signed [31:0]                pos_y,
  input  logic signed [31:0]                pos_z,
  input  logic signed [31:0]                dir_u,
  input  logic signed [31:0]                dir_v,
  output logic                              in_field,
  output logic                              w_is_zero,
  output logic [31:0]                       field_count
);

  logic [30:0] half_size;
  logic signed [31:0] plane;
  logic [ppc_pkg::CountBits-1:0] hit_counter;

  // Particle fields held for the whole item.
  logic w_neg;
  logic signed [31:0] px, py, pz;
  logic u_neg, v_neg;
  logic [31:0] um, vm;

  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] ssum;

  logic [61:0] rad;
  logic [30:0] root;
  logic [31:0] rrem;
  logic [33:0] rrem_sh;
  logic [33:0] rtrial;

  logic [32:0] dmag;
  logic t_neg;
  logic signed [32:0] diff;

  logic [30:0] drem;
  logic [30:0] dvd;
  logic [30:0] quot;
  logic [31:0] drem_sh;

  logic w_zero, div_ovf, x_ok, y_ok;
  logic [31:0] mul_a, mul_b;
  logic mul_en;
  logic in_box;

  function automatic logic in_range(input logic signed [31:0] pos, input logic neg,
                                    input logic [63:0] p, input logic [30:0] hs);
    logic signed [35:0] pe;
    logic signed [35:0] de;
    logic signed [35:0] xp;
    logic [35:0] mag;
    begin
      pe = 36'(pos);
      de = {2'b00, p[63:30]};
      xp = neg ? (pe - de) : (pe + de);
      mag = xp[35] ? 36'(-xp) : 36'(xp);
      in_range = (mag <= {5'b0, hs});
    end
  endfunction

  assign sts.w_zero = w_zero;
  assign sts.div_ovf = div_ovf;

  assign diff = 33'(plane) - 33'(pz);

  // Root step: bring down two radicand bits, try subtracting 4*root + 1.
  assign rrem_sh = {rrem, rad[61:60]};
  assign rtrial = {1'b0, root, 2'b01};

  // Divide step: bring down one dividend bit, try subtracting w.
  assign drem_sh = {drem, dvd[30]};

  always_comb begin
    mul_en = 1'b1;
    mul_a = um;
    mul_b = um;
    priority if (cmd.sq_v) begin
      mul_a = vm;
      mul_b = vm;
    end else if (cmd.mul_x) begin
      mul_b = {1'b0, quot};
    end else if (cmd.mul_y) begin
      mul_a = vm;
      mul_b = {1'b0, quot};
    end else if (!cmd.sq_u) begin
      mul_en = 1'b0;
    end
  end

  assign in_box = !w_zero && !div_ovf && x_ok && y_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_size <= ppc_pkg::HalfSizeReset;
      plane <= ppc_pkg::PlaneReset;
      hit_counter <= '0;
    end else begin
      if (cfg_we && cfg_addr == ppc_pkg::RegHalfSize) begin
        half_size <= cfg_data[30:0];
      end
      if (cfg_we && cfg_addr == ppc_pkg::RegPlane) begin
        plane <= cfg_data;
      end
      if (cmd.finish && in_box && hit_counter != '1) begin
        hit_counter <= hit_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_neg <= type_byte[7];
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
      u_neg <= dir_u[31];
      v_neg <= dir_v[31];
      um <= dir_u[31] ? 32'(-dir_u) : dir_u;
      vm <= dir_v[31] ? 32'(-dir_v) : dir_v;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.sq_v) begin
      acc <= prod;
    end
    if (cmd.sum) begin
      ssum <= acc + prod;
    end
    if (cmd.root_load) begin
      rad <= (ssum <= ppc_pkg::OneQ60) ? 62'(ppc_pkg::OneQ60 - ssum) : '0;
      root <= '0;
      rrem <= '0;
      dmag <= diff[32] ? 33'(-diff) : 33'(diff);
      t_neg <= diff[32] ^ w_neg;
    end
    if (cmd.root_step) begin
      rad <= {rad[59:0], 2'b00};
      if (rrem_sh >= rtrial) begin
        rrem <= 32'(rrem_sh - rtrial);
        root <= {root[29:0], 1'b1};
      end else begin
        rrem <= rrem_sh[31:0];
        root <= {root[29:0], 1'b0};
      end
    end
    if (cmd.div_load) begin
      w_zero <= (root == '0);
      // The quotient needs more than 31 bits exactly when the top dividend bits reach w.
      div_ovf <= (dmag[32:1] >= {1'b0, root});
      drem <= dmag[31:1];
      dvd <= {dmag[0], 30'b0};
      quot <= '0;
    end
    if (cmd.div_step) begin
      dvd <= {dvd[29:0], 1'b0};
      if (drem_sh >= {1'b0, root}) begin
        drem <= 31'(drem_sh - {1'b0, root});
        quot <= {quot[29:0], 1'b1};
      end else begin
        drem <= drem_sh[30:0];
        quot <= {quot[29:0], 1'b0};
      end
    end
    if (cmd.mul_y) begin
      x_ok <= in_range(px, u_neg ^ t_neg, prod, half_size);
    end
    if (cmd.chk_y) begin
      y_ok <= in_range(py, v_neg ^ t_neg, prod, half_size);
    end
    if (cmd.finish) begin
      in_field <= in_box;
      w_is_zero <= w_zero;
    end
  end

  assign field_count = (hit_counter > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(hit_counter);

endmodule

// File: sv/particle_plane_projection_counter_unit.sv
// Top level of the particle plane projection counter.
//
//   channel   direction  handshake           contents
//   s_*       in         s_tvalid/s_tready   one particle word
//   m_*       out        m_tvalid/m_tready   in-field flag, zero-w flag, running count
//   cfg_*     in         cfg_valid/cfg_ready register index and value
//
// One particle runs from acceptance to its result word through the 31-step root and
// the 31-step divide, one result bit per cycle each; the divide is skipped when w is
// zero or the path length overflows.
// A new particle is accepted once the previous result sits in the output register.
// Reset restores the field half size to 5 cm, the plane to 100 cm and clears the count.
// A stalled output holds its word; configuration writes are accepted in every cycle.
module particle_plane_projection_counter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // type_byte, pos_x, pos_y, pos_z, dir_u, dir_v
  input  logic [ppc_pkg::InBits-1:0]        s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // in_field, w_is_zero, field_count, zero fill
  output logic [ppc_pkg::OutBits-1:0]       m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppc_pkg::CfgAddrBits-1:0]   cfg_addr,
  input  logic [31:0]                       cfg_data
);

  ppc_pkg::cmd_t cmd;
  ppc_pkg::sts_t sts;
  logic in_field;
  logic w_is_zero;
  logic [31:0] field_count;

  assign cfg_ready = 1'b1;

  ppc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .type_byte   (s_tdata[7:0]),
    .pos_x       (s_tdata[39:8]),
    .pos_y       (s_tdata[71:40]),
    .pos_z       (s_tdata[103:72]),
    .dir_u       (s_tdata[135:104]),
    .dir_v       (s_tdata[167:136]),
    .in_field    (in_field),
    .w_is_zero   (w_is_zero),
    .field_count (field_count)
  );

  assign m_tdata = {6'b0, field_count, w_is_zero, in_field};

endmodule
